FILE: rtl/core/ps2_device_frame_engine_defines.svh
// assertion macros used by the ps2 device frame engine state machine
`ifndef PS2_DEVICE_FRAME_ENGINE_DEFINES_SVH
`define PS2_DEVICE_FRAME_ENGINE_DEFINES_SVH

// same-cycle check, sampled on the rising clock, off during reset
`define PS2DFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle check after a trigger
`define PS2DFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ps2dfe_pkg.sv
// types and constants of the ps2 device frame engine
`timescale 1ns / 1ps
package ps2dfe_pkg;

  typedef struct packed {
    logic       clock_line;
    logic       data_line;
    logic       send_request;
    logic [7:0] send_value;
    logic       receive_arm;
  } ps2dfe_in_t;

  typedef struct packed {
    logic       clock_pull;
    logic       data_pull;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] received_value;
  } ps2dfe_out_t;

  typedef struct packed {
    logic [9:0]  half_period_ticks;
    logic [9:0]  low_pulse_ticks;
    logic [11:0] byte_gap_ticks;
    logic [15:0] host_timeout_ticks;
  } ps2dfe_cfg_t;

  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_HALF_PERIOD  = 2'd0,
    CFG_LOW_PULSE    = 2'd1,
    CFG_BYTE_GAP     = 2'd2,
    CFG_HOST_TIMEOUT = 2'd3
  } ps2dfe_cfg_idx_e;

  localparam logic [9:0]  HalfPeriodReset  = 10'd20;
  localparam logic [9:0]  LowPulseReset    = 10'd40;
  localparam logic [11:0] ByteGapReset     = 12'd50;
  localparam logic [15:0] HostTimeoutReset = 16'd30000;

  typedef enum logic [2:0] {
    ST_SENT         = 3'd0,
    ST_CLK_INHIBIT  = 3'd1,
    ST_HOST_REQUEST = 3'd2,
    ST_RX_OK        = 3'd3,
    ST_PARITY_ERR   = 3'd4,
    ST_TIMEOUT      = 3'd5
  } ps2dfe_status_e;

  // frame bit positions
  localparam logic [3:0] BitParity  = 4'd8;
  localparam logic [3:0] BitTxPar   = 4'd9;
  localparam logic [3:0] BitRxLast  = 4'd10;
  localparam logic [3:0] BitTxLast  = 4'd11;

endpackage

FILE: rtl/core/ps2dfe_cfg_regs.sv
// configuration registers of the ps2 device frame engine
`timescale 1ns / 1ps
module ps2dfe_cfg_regs
  import ps2dfe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output ps2dfe_cfg_t          cfg_o
);

  ps2dfe_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ps2dfe_cfg_idx_e'(cfg_index_i))
        CFG_HALF_PERIOD:  cfg_d.half_period_ticks  = cfg_data_i[9:0];
        CFG_LOW_PULSE:    cfg_d.low_pulse_ticks    = cfg_data_i[9:0];
        CFG_BYTE_GAP:     cfg_d.byte_gap_ticks     = cfg_data_i[11:0];
        CFG_HOST_TIMEOUT: cfg_d.host_timeout_ticks = cfg_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks  <= HalfPeriodReset;
      cfg_q.low_pulse_ticks    <= LowPulseReset;
      cfg_q.byte_gap_ticks     <= ByteGapReset;
      cfg_q.host_timeout_ticks <= HostTimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ps2dfe_in_stage.sv
// input word register of the ps2 device frame engine
`timescale 1ns / 1ps
module ps2dfe_in_stage
  import ps2dfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ps2dfe_in_t in_item_i,
  input  logic       step_i,
  output logic       valid_o,
  output ps2dfe_in_t item_o
);

  logic       valid_q;
  ps2dfe_in_t item_q;

  // a held word only blocks the input while it cannot move on
  assign in_stall_o = valid_q && !step_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/ps2dfe_fsm.sv
// frame state machine: one line tick per step, result built from next state
`timescale 1ns / 1ps
`include "ps2_device_frame_engine_defines.svh"
module ps2dfe_fsm
  import ps2dfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  ps2dfe_in_t  item_i,
  input  ps2dfe_cfg_t cfg_i,
  output ps2dfe_out_t res_o
);

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_TX_GAP1   = 13'b0000000000010,
    PH_TX_LEAD   = 13'b0000000000100,
    PH_TX_LOW    = 13'b0000000001000,
    PH_TX_TRAIL  = 13'b0000000010000,
    PH_TX_GAP2   = 13'b0000000100000,
    PH_RX_WAIT   = 13'b0000001000000,
    PH_RX_LEAD   = 13'b0000010000000,
    PH_RX_LOW    = 13'b0000100000000,
    PH_RX_TRAIL  = 13'b0001000000000,
    PH_ACK_LEAD  = 13'b0010000000000,
    PH_ACK_LOW   = 13'b0100000000000,
    PH_ACK_TRAIL = 13'b1000000000000
  } ps2dfe_phase_e;

  ps2dfe_phase_e phase_q, phase_d;
  logic [3:0]    bit_index_q, bit_index_d;
  logic [7:0]    shift_byte_q, shift_byte_d;
  logic          parity_acc_q, parity_acc_d;
  logic          sampled_parity_q, sampled_parity_d;
  logic [15:0]   tick_count_q, tick_count_d;

  logic [15:0]   tick_inc;
  logic [9:0]    seg_dur;
  logic          seg_over;
  logic          gap_over;
  logic          done;
  logic [2:0]    status;
  logic [7:0]    rval;
  logic          tx_bit;

  assign tick_inc = tick_count_q + 16'd1;
  assign gap_over = tick_count_q >= {4'd0, cfg_i.byte_gap_ticks};

  always_comb begin
    case (phase_q)
      PH_TX_LOW, PH_RX_LOW, PH_ACK_LOW: seg_dur = cfg_i.low_pulse_ticks;
      default:                          seg_dur = cfg_i.half_period_ticks;
    endcase
  end

  assign seg_over = tick_inc >= {6'd0, seg_dur};

  always_comb begin
    phase_d          = phase_q;
    bit_index_d      = bit_index_q;
    shift_byte_d     = shift_byte_q;
    parity_acc_d     = parity_acc_q;
    sampled_parity_d = sampled_parity_q;
    tick_count_d     = tick_count_q;
    done             = 1'b0;
    status           = ST_SENT;
    rval             = 8'd0;

    case (phase_q)
      PH_IDLE: begin
        if (item_i.send_request) begin
          shift_byte_d = item_i.send_value;
          parity_acc_d = ~^item_i.send_value;
          tick_count_d = 16'd0;
          phase_d      = PH_TX_GAP1;
        end else if (item_i.receive_arm) begin
          shift_byte_d     = 8'd0;
          parity_acc_d     = 1'b1;
          sampled_parity_d = 1'b0;
          tick_count_d     = 16'd0;
          phase_d          = PH_RX_WAIT;
        end
      end
      PH_TX_GAP1: begin
        if (gap_over) begin
          tick_count_d = 16'd0;
          if (!item_i.clock_line) begin
            done    = 1'b1;
            status  = ST_CLK_INHIBIT;
            phase_d = PH_IDLE;
          end else if (!item_i.data_line) begin
            done    = 1'b1;
            status  = ST_HOST_REQUEST;
            phase_d = PH_IDLE;
          end else begin
            bit_index_d = 4'd0;
            phase_d     = PH_TX_LEAD;
          end
        end else begin
          tick_count_d = tick_inc;
        end
      end
      PH_TX_LEAD, PH_TX_LOW, PH_RX_LEAD, PH_RX_LOW, PH_ACK_LEAD, PH_ACK_LOW: begin
        tick_count_d = seg_over ? 16'd0 : tick_inc;
        if (seg_over) begin
          case (phase_q)
            PH_TX_LEAD:  phase_d = PH_TX_LOW;
            PH_TX_LOW:   phase_d = PH_TX_TRAIL;
            PH_RX_LEAD:  phase_d = PH_RX_LOW;
            PH_RX_LOW:   phase_d = PH_RX_TRAIL;
            PH_ACK_LEAD: phase_d = PH_ACK_LOW;
            default:     phase_d = PH_ACK_TRAIL;
          endcase
        end
      end
      PH_TX_TRAIL: begin
        tick_count_d = seg_over ? 16'd0 : tick_inc;
        if (seg_over) begin
          bit_index_d = bit_index_q + 4'd1;
          phase_d     = (bit_index_d >= BitTxLast) ? PH_TX_GAP2 : PH_TX_LEAD;
        end
      end
      PH_TX_GAP2: begin
        if (gap_over) begin
          tick_count_d = 16'd0;
          done         = 1'b1;
          status       = ST_SENT;
          phase_d      = PH_IDLE;
        end else begin
          tick_count_d = tick_inc;
        end
      end
      PH_RX_WAIT: begin
        // host request to send: data low while clock released
        if (!item_i.data_line && item_i.clock_line) begin
          tick_count_d = 16'd0;
          bit_index_d  = 4'd0;
          phase_d      = PH_RX_LEAD;
        end else if (tick_count_q >= cfg_i.host_timeout_ticks) begin
          tick_count_d = 16'd0;
          done         = 1'b1;
          status       = ST_TIMEOUT;
          phase_d      = PH_IDLE;
        end else begin
          tick_count_d = tick_inc;
        end
      end
      PH_RX_TRAIL: begin
        tick_count_d = seg_over ? 16'd0 : tick_inc;
        if (seg_over) begin
          if (!bit_index_q[3]) begin
            if (item_i.data_line) begin
              shift_byte_d[bit_index_q[2:0]] = 1'b1;
              parity_acc_d                   = ~parity_acc_q;
            end
          end else if (bit_index_q == BitParity) begin
            sampled_parity_d = item_i.data_line;
          end
          bit_index_d = bit_index_q + 4'd1;
          phase_d     = (bit_index_d >= BitRxLast) ? PH_ACK_LEAD : PH_RX_LEAD;
        end
      end
      PH_ACK_TRAIL: begin
        tick_count_d = seg_over ? 16'd0 : tick_inc;
        if (seg_over) begin
          done    = 1'b1;
          status  = (sampled_parity_q == parity_acc_q) ? ST_RX_OK : ST_PARITY_ERR;
          rval    = shift_byte_q;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d      = PH_IDLE;
        tick_count_d = 16'd0;
      end
    endcase
  end

  // level driven for the frame bit after this tick: start, data, parity, stop
  always_comb begin
    if (bit_index_d == 4'd0) begin
      tx_bit = 1'b0;
    end else if (bit_index_d <= BitParity) begin
      tx_bit = shift_byte_d[3'(bit_index_d - 4'd1)];
    end else if (bit_index_d == BitTxPar) begin
      tx_bit = parity_acc_d;
    end else begin
      tx_bit = 1'b1;
    end
  end

  always_comb begin
    res_o.clock_pull = (phase_d == PH_TX_LOW) || (phase_d == PH_RX_LOW) ||
                       (phase_d == PH_ACK_LOW);
    case (phase_d)
      PH_TX_LEAD, PH_TX_LOW, PH_TX_TRAIL:    res_o.data_pull = ~tx_bit;
      PH_ACK_LEAD, PH_ACK_LOW, PH_ACK_TRAIL: res_o.data_pull = 1'b1;
      default:                               res_o.data_pull = 1'b0;
    endcase
    res_o.busy_res       = phase_d != PH_IDLE;
    res_o.done_res       = done;
    res_o.status         = status;
    res_o.received_value = rval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      bit_index_q      <= 4'd0;
      shift_byte_q     <= 8'd0;
      parity_acc_q     <= 1'b1;
      sampled_parity_q <= 1'b0;
      tick_count_q     <= 16'd0;
    end else if (step_i) begin
      phase_q          <= phase_d;
      bit_index_q      <= bit_index_d;
      shift_byte_q     <= shift_byte_d;
      parity_acc_q     <= parity_acc_d;
      sampled_parity_q <= sampled_parity_d;
      tick_count_q     <= tick_count_d;
    end
  end

  `PS2DFE_ASSERT(a_done_leaves_idle, res_o.done_res |-> !res_o.busy_res, "done while busy")
  `PS2DFE_ASSERT(a_pull_only_busy, (res_o.clock_pull || res_o.data_pull) |-> res_o.busy_res, "line pulled while idle")
  `PS2DFE_ASSERT(a_status_needs_done, (res_o.status != ST_SENT) |-> res_o.done_res, "status without done")
  `PS2DFE_ASSERT_NEXT(a_send_wins, step_i && phase_q == PH_IDLE && item_i.send_request, phase_q == PH_TX_GAP1, "send request not taken")

endmodule

FILE: rtl/core/ps2dfe_out_stage.sv
// result word register of the ps2 device frame engine
`timescale 1ns / 1ps
module ps2dfe_out_stage
  import ps2dfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ps2dfe_out_t res_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ps2dfe_out_t out_result_o
);

  logic        valid_q;
  ps2dfe_out_t res_q;

  // free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = res_q;

endmodule

FILE: rtl/core/ps2_device_frame_engine.sv
// ps2 device frame engine top level
// Device side of a PS/2 link, clocked by one line tick per input word.
// Input channel (in_valid_i / in_stall_o / in_item_i): each word carries the
// sampled clock and data lines plus the send and receive-arm requests; the
// requests are only looked at while the engine is idle.
// Output channel (out_valid_o / out_stall_i / out_result_o): exactly one
// result word per input word, giving the line pulls to drive, busy, done,
// status and the received byte.
// An accepted input word is held in the input register, then the frame state
// update turns it into the word loaded into the result register.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; after that the input stalls too.
// The cfg port writes a timing register at once, with no wait.
// Reset clears both registers, returns the frame state to idle and loads the
// default timing (20 / 40 / 50 / 30000 ticks).
`timescale 1ns / 1ps
module ps2_device_frame_engine
  import ps2dfe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ps2dfe_in_t           in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ps2dfe_out_t          out_result_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  ps2dfe_cfg_t cfg;
  ps2dfe_in_t  item;
  ps2dfe_out_t res;
  logic        item_valid;
  logic        out_ready;
  logic        step;

  assign step = item_valid && out_ready;

  ps2dfe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ps2dfe_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .step_i     (step),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  ps2dfe_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  ps2dfe_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .res_i        (res),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

endmodule
